// ===== rtl/core/packed_block_key_index_defines.svh =====
// assertion macros shared by the index modules
`ifndef PACKED_BLOCK_KEY_INDEX_DEFINES_SVH
`define PACKED_BLOCK_KEY_INDEX_DEFINES_SVH

`ifndef SYNTH
`define PBKI_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pbki check failed");
`define PBKI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbki check failed");
`else
`define PBKI_ASSERT(lbl, expr)
`define PBKI_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/pbki_pkg.sv =====
package pbki_pkg;

    typedef enum logic [1:0]
    {
        MD_ADD    = 2'd0,
        MD_GET    = 2'd1,
        MD_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_UPDATED   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed
    {
        logic done;
        logic found;
    } scan_stat_t;

endpackage

// ===== rtl/core/pbki_if.sv =====
interface pbki_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] bucket_id;
    logic [63:0] record_in;

    modport source (output valid, mode, key, bucket_id, record_in, input ready);
    modport sink (input valid, mode, key, bucket_id, record_in, output ready);
endinterface

interface pbki_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] record_out;
    logic [7:0]  stored_count;
    logic [7:0]  valid_count;

    modport source (output valid, status, record_out, stored_count, valid_count,
                    input ready);
    modport sink (input valid, status, record_out, stored_count, valid_count,
                  output ready);
endinterface

// ===== rtl/core/pbki_key_scan.sv =====
`include "packed_block_key_index_defines.svh"

module pbki_key_scan
    import pbki_pkg::*;
#(
    parameter int MAX_ENTRIES = 128,
    localparam int IDX_W = $clog2(MAX_ENTRIES),
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [63:0]      key,
    input  logic [CNT_W-1:0] count,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [63:0]      wr_key,
    output scan_stat_t       stat,
    output logic [IDX_W-1:0] idx
);

    typedef enum logic
    {
        SC_IDLE,
        SC_SCAN
    } sc_state_t;

    logic [63:0]      key_mem [MAX_ENTRIES];
    logic [63:0]      rd_reg;
    sc_state_t        state_reg;
    logic             v_reg;
    logic [IDX_W-1:0] cidx_reg;
    logic [CNT_W-1:0] raddr_reg;
    logic             issue;
    logic             hit;
    logic             miss;

    // one key read per cycle, compared in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx] <= wr_key;
        end
        rd_reg <= key_mem[raddr_reg[IDX_W-1:0]];
    end

    assign issue = (raddr_reg < count);
    assign hit   = (state_reg == SC_SCAN) && v_reg && (rd_reg == key);
    assign miss  = (state_reg == SC_SCAN) && !v_reg && !issue;

    assign stat.done  = hit || miss;
    assign stat.found = hit;
    assign idx        = cidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            v_reg     <= 1'b0;
            cidx_reg  <= '0;
            raddr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                SC_IDLE:
                begin
                    v_reg <= 1'b0;
                    if (start)
                    begin
                        raddr_reg <= '0;
                        state_reg <= SC_SCAN;
                    end
                end
                SC_SCAN:
                begin
                    if (hit || miss)
                    begin
                        v_reg     <= 1'b0;
                        state_reg <= SC_IDLE;
                    end
                    else
                    begin
                        v_reg    <= issue;
                        cidx_reg <= raddr_reg[IDX_W-1:0];
                        if (issue)
                        begin
                            raddr_reg <= raddr_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

    `PBKI_ASSERT_IMP(a_scan_cidx_range, v_reg, CNT_W'(cidx_reg) < count)
    `PBKI_ASSERT_IMP(a_scan_start_idle, start, state_reg == SC_IDLE)
    `PBKI_ASSERT_IMP(a_scan_addr_bound, state_reg == SC_SCAN, raddr_reg <= count)

endmodule

// ===== rtl/core/packed_block_key_index.sv =====
// a request passes through the key scan, a fetch of the entry stores and a decide step that
// writes the response register once it is free; the response may be held off by rsp.ready
// one request at a time: a new one is taken only in idle, after the last one is decided
// the linear key search reads one stored key per cycle from a key memory with one read port
// reset: counts to zero and record top to the block end; entry memories are not
// cleared and are only read below the stored count, so no clearing pass is needed
`include "packed_block_key_index_defines.svh"

module packed_block_key_index
    import pbki_pkg::*;
#(
    parameter int BLOCK_BYTES   = 4096,
    parameter int HEADER_BYTES  = 16,
    parameter int POSINFO_BYTES = 24,
    parameter int RECORD_BYTES  = 8,
    parameter int MAX_ENTRIES   = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    pbki_req_if.sink   req,
    pbki_rsp_if.source rsp
);

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int TOP_W   = $clog2(BLOCK_BYTES + 1);
    localparam int LIM_MAX = HEADER_BYTES + (MAX_ENTRIES + 1) * POSINFO_BYTES;
    localparam int LIM_W   = $clog2(LIM_MAX + 1);
    localparam int CMP_W   = (TOP_W > LIM_W) ? TOP_W : LIM_W;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_DECIDE
    } state_t;

    // entry stores beside the key memory
    logic [63:0] bid_mem [MAX_ENTRIES];
    logic [63:0] rec_mem [MAX_ENTRIES];
    logic        rm_mem  [MAX_ENTRIES];
    logic [63:0] rec_rd_reg;
    logic        rm_rd_reg;

    state_t           state_reg,   state_next;
    mode_t            mode_reg,    mode_next;
    logic [63:0]      key_reg,     key_next;
    logic [63:0]      bid_reg,     bid_next;
    logic [63:0]      recin_reg,   recin_next;
    logic [IDX_W-1:0] idx_reg,     idx_next;
    logic             found_reg,   found_next;
    logic [CNT_W-1:0] stored_reg,  stored_next;
    logic [CNT_W-1:0] valid_reg,   valid_next;
    logic [TOP_W-1:0] top_reg,     top_next;
    logic [LIM_W-1:0] limit_reg,   limit_next;
    logic             ovalid_reg,  ovalid_next;
    status_t          ostatus_reg, ostatus_next;
    logic [63:0]      orec_reg,    orec_next;
    logic [7:0]       ostored_reg, ostored_next;
    logic [7:0]       ovalidc_reg, ovalidc_next;

    logic             scan_start;
    scan_stat_t       scan_stat;
    logic [IDX_W-1:0] scan_idx;

    logic             rec_we;
    logic [IDX_W-1:0] rec_widx;
    logic             rm_we;
    logic             rm_wval;
    logic             app_we;
    logic             live;
    logic             full;
    logic [CMP_W-1:0] top_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CNT_W+7:0] stored_ext;
    logic [CNT_W+7:0] valid_ext;

    pbki_key_scan #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_start),
        .key    (key_reg),
        .count  (stored_reg),
        .wr_en  (app_we),
        .wr_idx (stored_reg[IDX_W-1:0]),
        .wr_key (key_reg),
        .stat   (scan_stat),
        .idx    (scan_idx)
    );

    always_ff @(posedge clk)
    begin
        if (app_we)
        begin
            bid_mem[stored_reg[IDX_W-1:0]] <= bid_reg;
        end
        if (rec_we)
        begin
            rec_mem[rec_widx] <= recin_reg;
        end
        if (rm_we)
        begin
            rm_mem[rec_widx] <= rm_wval;
        end
        rec_rd_reg <= rec_mem[idx_reg];
        rm_rd_reg  <= rm_mem[idx_reg];
    end

    assign req.ready = (state_reg == S_IDLE);
    assign live      = found_reg && !rm_rd_reg;
    assign top_ext   = CMP_W'(top_reg);
    assign pos_ext   = top_ext - CMP_W'(RECORD_BYTES);
    assign full      = (stored_reg >= CNT_W'(MAX_ENTRIES))
                    || (top_ext < CMP_W'(RECORD_BYTES))
                    || (pos_ext < CMP_W'(limit_reg));
    assign stored_ext = {8'd0, stored_next};
    assign valid_ext  = {8'd0, valid_next};

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        bid_next     = bid_reg;
        recin_next   = recin_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        stored_next  = stored_reg;
        valid_next   = valid_reg;
        top_next     = top_reg;
        limit_next   = limit_reg;
        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        orec_next    = orec_reg;
        ostored_next = ostored_reg;
        ovalidc_next = ovalidc_reg;
        scan_start   = 1'b0;
        rec_we       = 1'b0;
        rec_widx     = idx_reg;
        rm_we        = 1'b0;
        rm_wval      = 1'b0;
        app_we       = 1'b0;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = mode_t'(req.mode);
                    key_next   = req.key;
                    bid_next   = req.bucket_id;
                    recin_next = req.record_in;
                    scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_stat.done)
                begin
                    idx_next   = scan_idx;
                    found_next = scan_stat.found;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                // wait until the response register is free
                if (!ovalid_reg || rsp.ready)
                begin
                    ostatus_next = ST_NOT_FOUND;
                    orec_next    = '0;
                    case (mode_reg)
                        MD_ADD:
                        begin
                            if (found_reg)
                            begin
                                rec_we = 1'b1;
                                if (rm_rd_reg)
                                begin
                                    // revive a removed key
                                    rm_we        = 1'b1;
                                    rm_wval      = 1'b0;
                                    valid_next   = valid_reg + 1'b1;
                                    ostatus_next = ST_OK;
                                end
                                else
                                begin
                                    ostatus_next = ST_UPDATED;
                                end
                            end
                            else if (full)
                            begin
                                ostatus_next = ST_FULL;
                            end
                            else
                            begin
                                app_we       = 1'b1;
                                rec_we       = 1'b1;
                                rec_widx     = stored_reg[IDX_W-1:0];
                                rm_we        = 1'b1;
                                rm_wval      = 1'b0;
                                stored_next  = stored_reg + 1'b1;
                                valid_next   = valid_reg + 1'b1;
                                top_next     = pos_ext[TOP_W-1:0];
                                limit_next   = limit_reg + LIM_W'(POSINFO_BYTES);
                                ostatus_next = ST_OK;
                            end
                        end
                        MD_GET:
                        begin
                            if (live)
                            begin
                                orec_next    = rec_rd_reg;
                                ostatus_next = ST_OK;
                            end
                        end
                        MD_REMOVE:
                        begin
                            if (live)
                            begin
                                rm_we   = 1'b1;
                                rm_wval = 1'b1;
                                if (valid_reg != '0)
                                begin
                                    valid_next = valid_reg - 1'b1;
                                end
                                ostatus_next = ST_OK;
                            end
                        end
                        default:
                        begin
                            ostatus_next = ST_NOT_FOUND;
                        end
                    endcase
                    ostored_next = stored_ext[7:0];
                    ovalidc_next = valid_ext[7:0];
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= MD_GET;
            key_reg     <= '0;
            bid_reg     <= '0;
            recin_reg   <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            stored_reg  <= '0;
            valid_reg   <= '0;
            top_reg     <= TOP_W'(BLOCK_BYTES);
            limit_reg   <= LIM_W'(HEADER_BYTES + POSINFO_BYTES);
            ovalid_reg  <= 1'b0;
            ostatus_reg <= ST_NOT_FOUND;
            orec_reg    <= '0;
            ostored_reg <= '0;
            ovalidc_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            key_reg     <= key_next;
            bid_reg     <= bid_next;
            recin_reg   <= recin_next;
            idx_reg     <= idx_next;
            found_reg   <= found_next;
            stored_reg  <= stored_next;
            valid_reg   <= valid_next;
            top_reg     <= top_next;
            limit_reg   <= limit_next;
            ovalid_reg  <= ovalid_next;
            ostatus_reg <= ostatus_next;
            orec_reg    <= orec_next;
            ostored_reg <= ostored_next;
            ovalidc_reg <= ovalidc_next;
        end
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = ostatus_reg;
    assign rsp.record_out   = orec_reg;
    assign rsp.stored_count = ostored_reg;
    assign rsp.valid_count  = ovalidc_reg;

    `PBKI_ASSERT(a_valid_le_stored, valid_reg <= stored_reg)
    `PBKI_ASSERT(a_stored_le_max, stored_reg <= CNT_W'(MAX_ENTRIES))
    `PBKI_ASSERT_IMP(a_append_moves_top, !$stable(stored_reg), !$stable(top_reg))
    `PBKI_ASSERT_IMP(a_scan_done_in_scan, scan_stat.done, state_reg == S_SCAN)

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pbki_pkg::*;

    localparam int BLOCK_BYTES      = 4096;
    localparam int HEADER_BYTES     = 16;
    localparam int POSINFO_BYTES    = 24;
    localparam int RECORD_BYTES     = 8;
    localparam int MAX_ENTRIES      = 128;
    localparam int CLK_HALF         = 10;
    localparam int RANDOM_REQUESTS  = 800;
    localparam int KEY_POOL_SIZE    = 140;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int LONG_HOLD_AFTER  = 60;
    localparam int MAX_REPORTED     = 10;

    // mode code that the block has no operation for
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed
    {
        logic [1:0]  mode;
        logic [63:0] key;
        logic [63:0] bucket_id;
        logic [63:0] record_in;
    } request_t;

    typedef struct packed
    {
        status_t     status;
        logic [63:0] record_out;
        logic [7:0]  stored_count;
        logic [7:0]  valid_count;
    } reply_t;

    class key_index_ledger;
        logic [63:0] keys_held[$];
        logic [63:0] buckets_held[$];
        logic [63:0] records_held[$];
        bit          dropped[$];
        int unsigned live_count;
        int unsigned record_floor;
        reply_t      awaited[$];
        int unsigned mismatches;
        int unsigned replies_checked;
        int unsigned status_tally[4];
        int unsigned peak_held;

        function new();
            live_count = 0;
            record_floor = BLOCK_BYTES;
            mismatches = 0;
            replies_checked = 0;
            peak_held = 0;
            foreach (status_tally[i])
            begin
                status_tally[i] = 0;
            end
        endfunction

        // works out the reply to one accepted request and updates the index copy
        function void note_request(request_t q);
            reply_t r;
            int     slot;
            slot = -1;
            foreach (keys_held[i])
            begin
                if (slot < 0 && keys_held[i] === q.key)
                    slot = i;
            end
            r.status = ST_NOT_FOUND;
            r.record_out = '0;
            case (q.mode)
                MD_ADD:
                begin
                    if (slot >= 0)
                    begin
                        records_held[slot] = q.record_in;
                        if (dropped[slot])
                        begin
                            // revive a removed key
                            dropped[slot] = 1'b0;
                            live_count++;
                            r.status = ST_OK;
                        end
                        else
                            r.status = ST_UPDATED;
                    end
                    else if (keys_held.size() >= MAX_ENTRIES || record_floor < RECORD_BYTES
                             || record_floor - RECORD_BYTES
                                < HEADER_BYTES + (keys_held.size() + 1) * POSINFO_BYTES)
                        r.status = ST_FULL;
                    else
                    begin
                        keys_held.push_back(q.key);
                        buckets_held.push_back(q.bucket_id);
                        records_held.push_back(q.record_in);
                        dropped.push_back(1'b0);
                        live_count++;
                        record_floor -= RECORD_BYTES;
                        r.status = ST_OK;
                    end
                end
                MD_GET:
                begin
                    if (slot >= 0 && !dropped[slot])
                    begin
                        r.status = ST_OK;
                        r.record_out = records_held[slot];
                    end
                end
                MD_REMOVE:
                begin
                    // space is never given back, only the mark is set
                    if (slot >= 0 && !dropped[slot])
                    begin
                        dropped[slot] = 1'b1;
                        if (live_count > 0)
                            live_count--;
                        r.status = ST_OK;
                    end
                end
                default:
                begin
                end
            endcase
            r.stored_count = 8'(keys_held.size());
            r.valid_count = 8'(live_count);
            status_tally[r.status]++;
            if (keys_held.size() > peak_held)
                peak_held = keys_held.size();
            awaited.push_back(r);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            replies_checked++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("%0t: reply with none pending: status %s record %h counts %0d/%0d",
                             $time, got.status.name(), got.record_out, got.stored_count,
                             got.valid_count);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.record_out !== want.record_out
                || got.stored_count !== want.stored_count
                || got.valid_count !== want.valid_count)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                begin
                    $display("%0t: reply %0d wrong: expected status %s record %h counts %0d/%0d",
                             $time, replies_checked, want.status.name(), want.record_out,
                             want.stored_count, want.valid_count);
                    $display("%0t: reply %0d wrong: got status %s record %h counts %0d/%0d",
                             $time, replies_checked, got.status.name(), got.record_out,
                             got.stored_count, got.valid_count);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pbki_req_if req();
    pbki_rsp_if rsp();

    packed_block_key_index dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    key_index_ledger ledger = new();

    always #CLK_HALF clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic request_t make_req(logic [1:0] m, logic [63:0] k, logic [63:0] b,
                                          logic [63:0] rec);
        request_t q;
        q.mode = m;
        q.key = k;
        q.bucket_id = b;
        q.record_in = rec;
        return q;
    endfunction

    // called at a rising edge; valid stays high when there is no gap
    task automatic send_beat(input request_t q, input int unsigned gap);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.mode <= q.mode;
        req.key <= q.key;
        req.bucket_id <= q.bucket_id;
        req.record_in <= q.record_in;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        ledger.note_request(q);
    endtask

    // called at a rising edge; drops valid so the last beat is not offered again
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : reply_sink
        reply_t      got;
        int unsigned hold_left;
        bit          eager;
        bit          long_hold_done;
        hold_left = 0;
        eager = 1'b0;
        long_hold_done = 1'b0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                got.status = status_t'(rsp.status);
                got.record_out = rsp.record_out;
                got.stored_count = rsp.stored_count;
                got.valid_count = rsp.valid_count;
                ledger.check_reply(got);
            end
            // one long hold so the block backs up into the request side
            if (!long_hold_done && ledger.replies_checked >= LONG_HOLD_AFTER)
            begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            else if (hold_left == 0 && !eager && $urandom_range(0, 7) == 0)
                hold_left = pick_gap();
            if ($urandom_range(0, 63) == 0)
                eager = !eager;
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin : request_source
        request_t    directed[$];
        request_t    q;
        logic [63:0] key_pool[$];
        logic [63:0] ones;
        logic [63:0] stray_key;
        logic [63:0] rec_a;
        logic [63:0] rec_b;
        int unsigned r;
        bit          eager;
        ones = '1;
        eager = 1'b0;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.mode <= MD_ADD;
        req.key <= '0;
        req.bucket_id <= '0;
        req.record_in <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stray_key = rand64();
        rec_a = rand64();
        rec_b = rand64();
        // empty index, extremes, update, remove twice, revive, unused mode
        directed.push_back(make_req(MD_GET, '0, '0, '0));
        directed.push_back(make_req(MD_REMOVE, '0, '0, '0));
        directed.push_back(make_req(MD_ADD, '0, '0, '0));
        directed.push_back(make_req(MD_ADD, ones, ones, ones));
        directed.push_back(make_req(MD_ADD, '0, rand64(), rec_a));
        directed.push_back(make_req(MD_GET, '0, '0, '0));
        directed.push_back(make_req(MD_GET, ones, '0, '0));
        directed.push_back(make_req(MD_GET, stray_key, '0, '0));
        directed.push_back(make_req(MD_REMOVE, '0, ones, ones));
        directed.push_back(make_req(MD_REMOVE, '0, '0, '0));
        directed.push_back(make_req(MD_GET, '0, '0, '0));
        directed.push_back(make_req(MD_ADD, '0, ones, rec_b));
        directed.push_back(make_req(MD_GET, '0, '0, '0));
        directed.push_back(make_req(MODE_UNUSED, ones, ones, ones));
        directed.push_back(make_req(MD_REMOVE, ones, '0, '0));
        directed.push_back(make_req(MD_ADD, ones, '0, '0));
        directed.push_back(make_req(MD_GET, ones, '0, '0));
        directed.push_back(make_req(MD_REMOVE, stray_key, '0, '0));
        directed.push_back(make_req(MD_ADD, stray_key, rand64(), rand64()));
        directed.push_back(make_req(MODE_UNUSED, '0, '0, '0));
        foreach (directed[i])
            send_beat(directed[i], pick_gap());
        wait_drained();

        // a bounded key pool keeps hits frequent and still fills the block
        key_pool.push_back('0);
        key_pool.push_back(ones);
        key_pool.push_back(stray_key);
        repeat (KEY_POOL_SIZE) key_pool.push_back(rand64());

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 48)
                q.mode = MD_ADD;
            else if (r < 73)
                q.mode = MD_GET;
            else if (r < 95)
                q.mode = MD_REMOVE;
            else
                q.mode = MODE_UNUSED;
            if ($urandom_range(0, 19) == 0)
                q.key = rand64();
            else
                q.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            q.bucket_id = rand64();
            q.record_in = rand64();
            if ($urandom_range(0, 49) == 0)
                eager = !eager;
            if (n == RANDOM_REQUESTS / 2)
            begin
                wait_drained();
                send_beat(q, 1);
            end
            else
                send_beat(q, eager ? 0 : pick_gap());
        end
        req.valid <= 1'b0;

        wait_drained();
        repeat (MAX_ENTRIES + 10) @(posedge clk);
        $display("checked %0d replies: %0d ok, %0d updated, %0d full, %0d not found",
                 ledger.replies_checked, ledger.status_tally[ST_OK],
                 ledger.status_tally[ST_UPDATED], ledger.status_tally[ST_FULL],
                 ledger.status_tally[ST_NOT_FOUND]);
        $display("index grew to %0d entries with %0d live at the end, %0d mismatches",
                 ledger.peak_held, ledger.live_count, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #30_000_000;
        $display("timeout after %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pbki_pkg.sv
rtl/core/pbki_if.sv
rtl/core/pbki_key_scan.sv
rtl/core/packed_block_key_index.sv
sim/tb_top.sv
